// ----- sv/dss_pkg.sv -----
package dss_pkg;

    // Store geometry
    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int WW    = 32;

    typedef logic [AW-1:0]        addr_t;
    typedef logic [CW-1:0]        count_t;
    typedef logic signed [WW-1:0] word_t;

    // Command codes carried on the input side
    typedef enum logic [2:0] {
        CMD_PUSH_A = 3'd0,
        CMD_PUSH_B = 3'd1,
        CMD_POP_A  = 3'd2,
        CMD_POP_B  = 3'd3,
        CMD_LIST_A = 3'd4,
        CMD_LIST_B = 3'd5
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    // Access request from the controller to the store
    typedef struct packed {
        logic  wr_en;
        addr_t wr_addr;
        logic  rd_en;
        addr_t rd_addr;
    } ram_req_t;

endpackage

// ----- sv/dual_stack_shared_memory.sv -----
// Channel   | Signals                                  | Fields, low bit up
// ----------+------------------------------------------+----------------------------------
// input     | s_axis_tvalid/tready, tuser, tdata       | tuser: cmd[2:0]; tdata: push_value
// output    | m_axis_tvalid/tready, tuser, tdata, tlast| tuser: status[1:0]; tdata: data
//
// A push, an overflow or an underflow passes the accept cycle (store write for a push
// that fits) and then the emit state, which loads the result register. A pop issues its
// store read at accept; the registered read data loads the result register in the
// readout state. A list of n words makes one store read port access per word.
// Reset clears both stack counts; store contents stay undefined until pushed.
// A stalled output holds the controller in place; the result register frees the
// input side once the final result of an item is loaded.
module dual_stack_shared_memory (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    input  logic [31:0] s_axis_tdata,   // push_value[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic [31:0] m_axis_tdata,   // data[31:0]
    output logic        m_axis_tlast
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EMIT,
        S_RDOUT
    } state_t;

    state_t             state_reg,      state_next;
    dss_pkg::count_t    count_a_reg,    count_a_next;
    dss_pkg::count_t    count_b_reg,    count_b_next;
    dss_pkg::addr_t     ptr_reg,        ptr_next;
    logic               is_list_reg,    is_list_next;
    logic               dir_b_reg,      dir_b_next;
    dss_pkg::status_t   res_status_reg, res_status_next;
    logic               out_valid_reg,  out_valid_next;
    dss_pkg::status_t   out_status_reg, out_status_next;
    dss_pkg::word_t     out_data_reg,   out_data_next;
    logic               out_last_reg,   out_last_next;

    dss_pkg::ram_req_t  ram_req;
    dss_pkg::word_t     ram_rd_data;

    logic               in_fire;
    logic               slot_free;
    logic               full;
    logic               list_last;
    dss_pkg::count_t    a_top;
    dss_pkg::count_t    b_push;
    dss_pkg::count_t    b_top;
    dss_pkg::addr_t     ptr_step;

    dss_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .wr_data (dss_pkg::word_t'(s_axis_tdata)),
        .rd_data (ram_rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    // Stack tops and fill check
    assign full   = ({1'b0, count_a_reg} + {1'b0, count_b_reg})
                    >= (dss_pkg::CW + 1)'(dss_pkg::DEPTH);
    assign a_top  = count_a_reg - dss_pkg::CW'(1);
    assign b_push = dss_pkg::CW'(dss_pkg::DEPTH - 1) - count_b_reg;
    assign b_top  = dss_pkg::CW'(dss_pkg::DEPTH) - count_b_reg;

    // List walk: A walks down to word 0, B walks up to the top word
    assign list_last = !is_list_reg ||
                       (dir_b_reg ? (ptr_reg == dss_pkg::AW'(dss_pkg::DEPTH - 1))
                                  : (ptr_reg == '0));
    assign ptr_step  = dir_b_reg ? (ptr_reg + dss_pkg::AW'(1)) : (ptr_reg - dss_pkg::AW'(1));

    always_comb
    begin
        state_next      = state_reg;
        count_a_next    = count_a_reg;
        count_b_next    = count_b_reg;
        ptr_next        = ptr_reg;
        is_list_next    = is_list_reg;
        dir_b_next      = dir_b_reg;
        res_status_next = res_status_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        ram_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Decode the item and start its store access
                if (in_fire)
                begin
                    unique case (s_axis_tuser)
                        dss_pkg::CMD_PUSH_A:
                        begin
                            state_next = S_EMIT;
                            if (full)
                            begin
                                res_status_next = dss_pkg::ST_OVER;
                            end
                            else
                            begin
                                res_status_next = dss_pkg::ST_OK;
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = count_a_reg[dss_pkg::AW-1:0];
                                count_a_next    = count_a_reg + dss_pkg::CW'(1);
                            end
                        end
                        dss_pkg::CMD_PUSH_B:
                        begin
                            state_next = S_EMIT;
                            if (full)
                            begin
                                res_status_next = dss_pkg::ST_OVER;
                            end
                            else
                            begin
                                res_status_next = dss_pkg::ST_OK;
                                ram_req.wr_en   = 1'b1;
                                ram_req.wr_addr = b_push[dss_pkg::AW-1:0];
                                count_b_next    = count_b_reg + dss_pkg::CW'(1);
                            end
                        end
                        dss_pkg::CMD_POP_A, dss_pkg::CMD_LIST_A:
                        begin
                            if (count_a_reg == '0)
                            begin
                                state_next      = S_EMIT;
                                res_status_next = dss_pkg::ST_UNDER;
                            end
                            else
                            begin
                                state_next      = S_RDOUT;
                                is_list_next    = (s_axis_tuser == dss_pkg::CMD_LIST_A);
                                dir_b_next      = 1'b0;
                                ptr_next        = a_top[dss_pkg::AW-1:0];
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = a_top[dss_pkg::AW-1:0];
                                if (s_axis_tuser == dss_pkg::CMD_POP_A)
                                begin
                                    count_a_next = a_top;
                                end
                            end
                        end
                        dss_pkg::CMD_POP_B, dss_pkg::CMD_LIST_B:
                        begin
                            if (count_b_reg == '0)
                            begin
                                state_next      = S_EMIT;
                                res_status_next = dss_pkg::ST_UNDER;
                            end
                            else
                            begin
                                state_next      = S_RDOUT;
                                is_list_next    = (s_axis_tuser == dss_pkg::CMD_LIST_B);
                                dir_b_next      = 1'b1;
                                ptr_next        = b_top[dss_pkg::AW-1:0];
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = b_top[dss_pkg::AW-1:0];
                                if (s_axis_tuser == dss_pkg::CMD_POP_B)
                                begin
                                    count_b_next = count_b_reg - dss_pkg::CW'(1);
                                end
                            end
                        end
                        default:
                        begin
                            // Drop unknown commands without a result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                // Load a status-only result once the output register frees
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_RDOUT:
            begin
                // Load the registered store word and fetch the next one of a list
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = dss_pkg::ST_OK;
                    out_data_next   = ram_rd_data;
                    out_last_next   = list_last;
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ptr_next        = ptr_step;
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = ptr_step;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            ptr_reg        <= '0;
            is_list_reg    <= 1'b0;
            dir_b_reg      <= 1'b0;
            res_status_reg <= dss_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= dss_pkg::ST_OK;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            ptr_reg        <= ptr_next;
            is_list_reg    <= is_list_next;
            dir_b_reg      <= dir_b_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- sv/dss_ram.sv -----
module dss_ram (
    input  logic              clk,
    input  dss_pkg::ram_req_t req,
    input  dss_pkg::word_t    wr_data,
    output dss_pkg::word_t    rd_data
);

    dss_pkg::word_t mem [dss_pkg::DEPTH];
    dss_pkg::word_t rd_data_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/dss_chk.sv -----
module dss_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [1:0]  m_axis_tuser,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    logic in_fire;
    logic known_cmd;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign known_cmd = (s_axis_tuser <= 3'(dss_pkg::CMD_LIST_B));

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Overflow and underflow results are single, final and carry no word
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != 2'(dss_pkg::ST_OK)) |->
            m_axis_tlast && (m_axis_tdata == '0))
        else $error("error result with data or without last");

    // A known command drops input ready right after it is accepted
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && known_cmd |=> !s_axis_tready)
        else $error("input ready right after a known command");

    // An unknown command is dropped and the input stays open
    a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !known_cmd |=> s_axis_tready)
        else $error("unknown command stalled the input");

endmodule

bind dual_stack_shared_memory dss_chk u_dss_chk (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

    // Command codes outside the defined set; the block must drop these silently
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS  = 450;
    localparam int TAIL_ITEMS    = 60;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4 * dss_pkg::DEPTH + 16;
    localparam int WATCHDOG      = 4000;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic [2:0]     cmd;
        dss_pkg::word_t value;
        logic           sync;   // wait here until every result has arrived
        int             pct;    // chance of an idle burst before this item
    } stack_cmd_t;

    typedef struct {
        dss_pkg::status_t status;
        dss_pkg::word_t   data;
        logic             last;
    } stack_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [2:0]  s_axis_tuser = dss_pkg::CMD_PUSH_A;    // cmd[2:0]
    logic [31:0] s_axis_tdata = '0;                     // push_value[31:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [1:0]  m_axis_tuser;                          // status[1:0]
    logic [31:0] m_axis_tdata;                          // data[31:0]
    logic        m_axis_tlast;

    stack_cmd_t    cmd_q[$];
    stack_result_t result_q[$];

    // Shadow copy of the shared store and both stack depths
    dss_pkg::word_t shadow_mem [dss_pkg::DEPTH];
    int    depth_a = 0;
    int    depth_b = 0;

    int   n_taken = 0;
    int   mismatches = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    int   stall_pct = 0;
    int   mon_cycles = 0;
    int   quiet_cycles = 0;
    logic next_valid;
    logic next_ready;

    dual_stack_shared_memory i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic stack_result_t make_result(dss_pkg::status_t st, dss_pkg::word_t d,
                                                  logic lst);
        stack_result_t r;
        r.status = st;
        r.data   = d;
        r.last   = lst;
        return r;
    endfunction

    // Apply one accepted command to the shadow stacks and queue its results
    task automatic apply_stack_cmd(input logic [2:0] cmd, input dss_pkg::word_t val);
        int i;
        case (cmd)
            dss_pkg::CMD_PUSH_A:
            begin
                if (depth_a + depth_b >= dss_pkg::DEPTH)
                    result_q.push_back(make_result(dss_pkg::ST_OVER, '0, 1'b1));
                else
                begin
                    shadow_mem[depth_a] = val;
                    depth_a++;
                    result_q.push_back(make_result(dss_pkg::ST_OK, '0, 1'b1));
                end
            end
            dss_pkg::CMD_PUSH_B:
            begin
                if (depth_a + depth_b >= dss_pkg::DEPTH)
                    result_q.push_back(make_result(dss_pkg::ST_OVER, '0, 1'b1));
                else
                begin
                    depth_b++;
                    shadow_mem[dss_pkg::DEPTH - depth_b] = val;
                    result_q.push_back(make_result(dss_pkg::ST_OK, '0, 1'b1));
                end
            end
            dss_pkg::CMD_POP_A:
            begin
                if (depth_a == 0)
                    result_q.push_back(make_result(dss_pkg::ST_UNDER, '0, 1'b1));
                else
                begin
                    depth_a--;
                    result_q.push_back(make_result(dss_pkg::ST_OK, shadow_mem[depth_a], 1'b1));
                end
            end
            dss_pkg::CMD_POP_B:
            begin
                if (depth_b == 0)
                    result_q.push_back(make_result(dss_pkg::ST_UNDER, '0, 1'b1));
                else
                begin
                    result_q.push_back(make_result(dss_pkg::ST_OK,
                                                   shadow_mem[dss_pkg::DEPTH - depth_b], 1'b1));
                    depth_b--;
                end
            end
            dss_pkg::CMD_LIST_A:
            begin
                if (depth_a == 0)
                    result_q.push_back(make_result(dss_pkg::ST_UNDER, '0, 1'b1));
                else
                    for (i = depth_a; i > 0; i--)
                        result_q.push_back(make_result(dss_pkg::ST_OK, shadow_mem[i - 1],
                                                       i == 1));
            end
            dss_pkg::CMD_LIST_B:
            begin
                if (depth_b == 0)
                    result_q.push_back(make_result(dss_pkg::ST_UNDER, '0, 1'b1));
                else
                    for (i = dss_pkg::DEPTH - depth_b; i < dss_pkg::DEPTH; i++)
                        result_q.push_back(make_result(dss_pkg::ST_OK, shadow_mem[i],
                                                       i == dss_pkg::DEPTH - 1));
            end
            default:
            begin
                // spare codes produce nothing
            end
        endcase
    endtask

    task automatic add_cmd(input logic [2:0] cmd, input dss_pkg::word_t val, input int pct);
        stack_cmd_t c;
        c.cmd   = cmd;
        c.value = val;
        c.sync  = 1'b0;
        c.pct   = pct;
        cmd_q.push_back(c);
    endtask

    function automatic dss_pkg::word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 45;
        endcase
    endfunction

    // Drive the command side from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_stack_cmd(s_axis_tuser, s_axis_tdata);
                void'(cmd_q.pop_front());
                n_taken++;
            end
            next_valid = 1'b0;
            if (s_axis_tvalid && !s_axis_tready)
                next_valid = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (cmd_q.size() > 0)
            begin
                if (cmd_q[0].sync)
                begin
                    if (result_q.size() == 0)
                        void'(cmd_q.pop_front());
                end
                else if (cmd_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < cmd_q[0].pct)
                    gap_left = $urandom_range(0, 7);
                else
                begin
                    next_valid = 1'b1;
                    s_axis_tuser <= cmd_q[0].cmd;
                    s_axis_tdata <= cmd_q[0].value;
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Check results and throttle the result side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: unexpected result status=%0d data=%h last=%b",
                                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    stack_result_t e;
                    e = result_q.pop_front();
                    if (m_axis_tuser != e.status || m_axis_tdata != e.data ||
                        m_axis_tlast != e.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: mismatch status %0d/%0d data %h/%h last %b/%b",
                                     $time, m_axis_tuser, e.status, m_axis_tdata, e.data,
                                     m_axis_tlast, e.last);
                    end
                end
            end

            // re-pick the stall rate now and then so calm stretches occur too
            if (mon_cycles % 64 == 0)
                stall_pct = pick_pct();
            mon_cycles++;

            // hold off once for a long stretch while commands keep coming
            if (!hold_done && n_taken >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end

            next_ready = 1'b1;
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_ready = 1'b0;
            end
            else if (cmd_q.size() > TAIL_ITEMS && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 7);
                next_ready = 1'b0;
            end
            m_axis_tready <= next_ready;
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        stack_cmd_t marker;
        int         n_rand;
        int         n;
        int         pct;
        int         k;
        logic [2:0] side_cmd;

        // Directed: empty stacks, spare codes, extreme words, lists and pops
        add_cmd(dss_pkg::CMD_LIST_A, 32'h1234_5678, 0);
        add_cmd(dss_pkg::CMD_LIST_B, 32'hFFFF_FFFF, 0);
        add_cmd(dss_pkg::CMD_POP_A, 32'h0000_0000, 0);
        add_cmd(dss_pkg::CMD_POP_B, 32'h8000_0000, 0);
        add_cmd(CMD_SPARE_6, 32'h7FFF_FFFF, 0);
        add_cmd(CMD_SPARE_7, 32'hDEAD_BEEF, 0);
        add_cmd(dss_pkg::CMD_PUSH_A, 32'h7FFF_FFFF, 0);
        add_cmd(dss_pkg::CMD_PUSH_A, 32'h8000_0000, 0);
        add_cmd(dss_pkg::CMD_PUSH_B, 32'h0000_0000, 0);
        add_cmd(dss_pkg::CMD_PUSH_B, 32'hFFFF_FFFF, 0);
        add_cmd(dss_pkg::CMD_PUSH_A, 32'h5555_5555, 0);
        add_cmd(dss_pkg::CMD_PUSH_B, 32'hAAAA_AAAA, 0);
        add_cmd(dss_pkg::CMD_LIST_A, 32'h0, 0);
        add_cmd(dss_pkg::CMD_LIST_B, 32'h0, 0);
        add_cmd(dss_pkg::CMD_POP_A, 32'h0, 0);
        add_cmd(dss_pkg::CMD_POP_B, 32'h0, 0);

        // pause the sender until every result so far has come back
        marker.cmd   = dss_pkg::CMD_PUSH_A;
        marker.value = '0;
        marker.sync  = 1'b1;
        marker.pct   = 0;
        cmd_q.push_back(marker);

        // Random: mostly fill and drain runs that reach full and empty stacks
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS)
        begin
            pct = pick_pct();
            k   = $urandom_range(0, 9);
            if (k <= 3)
            begin
                n = $urandom_range(3, 20);
                side_cmd = $urandom_range(0, 1) ? dss_pkg::CMD_PUSH_A : dss_pkg::CMD_PUSH_B;
                repeat (n)
                begin
                    if ($urandom_range(0, 2) == 0)
                        side_cmd = $urandom_range(0, 1) ? dss_pkg::CMD_PUSH_A
                                                        : dss_pkg::CMD_PUSH_B;
                    add_cmd(side_cmd, pick_word(), pct);
                end
                add_cmd(dss_pkg::CMD_LIST_A, pick_word(), pct);
                add_cmd(dss_pkg::CMD_LIST_B, pick_word(), pct);
                n_rand += n + 2;
            end
            else if (k <= 6)
            begin
                n = $urandom_range(2, 12);
                repeat (n)
                    add_cmd($urandom_range(0, 1) ? dss_pkg::CMD_POP_A : dss_pkg::CMD_POP_B,
                            pick_word(), pct);
                n_rand += n;
                if ($urandom_range(0, 1))
                begin
                    add_cmd($urandom_range(0, 1) ? dss_pkg::CMD_LIST_A : dss_pkg::CMD_LIST_B,
                            pick_word(), pct);
                    n_rand++;
                end
            end
            else if (k <= 8)
            begin
                n = $urandom_range(3, 8);
                repeat (n)
                    add_cmd(3'($urandom_range(0, 7)), pick_word(), pct);
                n_rand += n;
            end
            else
            begin
                add_cmd(dss_pkg::CMD_LIST_A, pick_word(), pct);
                add_cmd(dss_pkg::CMD_LIST_B, pick_word(), pct);
                n_rand += 2;
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last command, then for its results, then settle
        while (cmd_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (result_q.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
